// ===== hdl/fefp_pkg.sv =====
// ----------------------------------------------------------------------------
// fefp_pkg: shared types and codes of the front-end event frame parser
// Parse phases, result kinds, error codes and register indexes.
// ----------------------------------------------------------------------------
package fefp_pkg;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_TRIG,
        PH_MODE,
        PH_LENHI,
        PH_LENLO,
        PH_SIGNAL,
        PH_TRAILER
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_SIGNAL = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NO_EB   = 3'd1;
    localparam logic [2:0] ERR_NO_90   = 3'd2;
    localparam logic [2:0] ERR_TRIGGER = 3'd3;
    localparam logic [2:0] ERR_MODE    = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FRAME_COUNT  = 2'd0;
    localparam logic [1:0] REG_BOARD_OFFSET = 2'd1;
    localparam logic [1:0] REG_UNCOMP_CODE  = 2'd2;

    // frame constants
    localparam logic [7:0]  SYNC_BYTE_1      = 8'hEB;
    localparam logic [7:0]  SYNC_BYTE_2      = 8'h90;
    localparam logic [15:0] HEADER_LEN       = 16'd6;
    localparam logic [2:0]  TRAILER_BYTES    = 3'd4;
    // ceil(2^17 / 3): (x * RECIP_3) >> 17 equals x / 3 for every 16-bit x
    localparam logic [15:0] RECIP_3          = 16'd43691;

endpackage

// ===== hdl/frontend_event_frame_parser.sv =====
// ----------------------------------------------------------------------------
// frontend_event_frame_parser: splits a raw byte stream into events
// Header sync check, trigger/mode consistency, signal extraction, event done.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock and produces at most one result per
// byte: a signal, an event-done marker or an error. Each accepted byte is
// handled in the cycle it arrives; its result sits in the output register
// from the next cycle on. A new byte is accepted in
// every cycle in which the output register is empty or being drained, so the
// sustained rate is one byte per cycle; only a stalled output (o_out_valid
// high, i_out_ready low) holds off the input. After an error or an event done
// the parser waits for the first sync byte of frame 0 again. Registers on the
// APB port (frame count, board type offset, uncompressed mode code) are
// meant to be written only while the parser is idle.
module frontend_event_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [3:0]         o_board_id,
    output logic [14:0]        o_channel,
    output logic [15:0]        o_value,
    output logic [7:0]         o_trigger,
    output logic signed [4:0]  o_run_mode,
    output logic [2:0]         o_error_code,
    output logic [3:0]         o_error_frame,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------- configuration registers ----------------
    logic [3:0] r_frame_count;
    logic [3:0] r_board_offset;
    logic [4:0] r_uncomp_code;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= 4'd1;
            r_board_offset <= 4'd1;
            r_uncomp_code  <= 5'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fefp_pkg::REG_FRAME_COUNT:  r_frame_count  <= pwdata[3:0];
                fefp_pkg::REG_BOARD_OFFSET: r_board_offset <= pwdata[3:0];
                fefp_pkg::REG_UNCOMP_CODE:  r_uncomp_code  <= pwdata[4:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fefp_pkg::REG_FRAME_COUNT:  prdata = {28'd0, r_frame_count};
            fefp_pkg::REG_BOARD_OFFSET: prdata = {28'd0, r_board_offset};
            fefp_pkg::REG_UNCOMP_CODE:  prdata = {27'd0, r_uncomp_code};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- parser state ----------------
    fefp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_frame_index, n_frame_index;
    logic [3:0]  r_cur_board, n_cur_board;
    logic [7:0]  r_evt_trigger, n_evt_trigger;
    logic [4:0]  r_evt_mode, n_evt_mode;
    logic [7:0]  r_len_high, n_len_high;
    logic [14:0] r_sig_left, n_sig_left;
    logic [14:0] r_sig_index, n_sig_index;
    logic [1:0]  r_byte_in_sig, n_byte_in_sig;
    logic [7:0]  r_held_chan, n_held_chan;
    logic [7:0]  r_held_high, n_held_high;
    logic [2:0]  r_trailer_left, n_trailer_left;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [3:0]  r_board_id;
    logic [14:0] r_channel;
    logic [15:0] r_value;
    logic [7:0]  r_trigger;
    logic [4:0]  r_run_mode;
    logic [2:0]  r_error_code;
    logic [3:0]  r_error_frame;

    // result of the byte being accepted
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [3:0]  res_board;
    logic [14:0] res_channel;
    logic [15:0] res_value;
    logic [7:0]  res_trigger;
    logic [4:0]  res_mode;
    logic [2:0]  res_ecode;
    logic [3:0]  res_eframe;

    logic        in_acc;
    logic        uncomp;
    logic [4:0]  byte_mode;
    logic [15:0] frame_len;
    logic [15:0] body_len;
    logic [31:0] div3_prod;
    logic [3:0]  frame_next;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    assign uncomp     = (r_evt_mode == r_uncomp_code);
    assign byte_mode  = {1'b0, i_data_byte[7:4]} - {1'b0, r_board_offset};
    assign frame_len  = {r_len_high, i_data_byte};
    assign body_len   = frame_len - fefp_pkg::HEADER_LEN;
    assign div3_prod  = body_len * fefp_pkg::RECIP_3;
    assign frame_next = r_frame_index + 4'd1;

    always_comb begin
        n_phase        = r_phase;
        n_frame_index  = r_frame_index;
        n_cur_board    = r_cur_board;
        n_evt_trigger  = r_evt_trigger;
        n_evt_mode     = r_evt_mode;
        n_len_high     = r_len_high;
        n_sig_left     = r_sig_left;
        n_sig_index    = r_sig_index;
        n_byte_in_sig  = r_byte_in_sig;
        n_held_chan    = r_held_chan;
        n_held_high    = r_held_high;
        n_trailer_left = r_trailer_left;

        res_valid   = 1'b0;
        res_kind    = fefp_pkg::KIND_SIGNAL;
        res_board   = 4'd0;
        res_channel = 15'd0;
        res_value   = 16'd0;
        res_trigger = 8'd0;
        res_mode    = 5'd0;
        res_ecode   = fefp_pkg::ERR_NONE;
        res_eframe  = 4'd0;

        unique case (r_phase)
            fefp_pkg::PH_SYNC1: begin
                if (i_data_byte != fefp_pkg::SYNC_BYTE_1) begin
                    res_valid  = 1'b1;
                    res_ecode  = fefp_pkg::ERR_NO_EB;
                    res_eframe = frame_next;
                end else begin
                    n_phase = fefp_pkg::PH_SYNC2;
                end
            end
            fefp_pkg::PH_SYNC2: begin
                if (i_data_byte != fefp_pkg::SYNC_BYTE_2) begin
                    res_valid  = 1'b1;
                    res_ecode  = fefp_pkg::ERR_NO_90;
                    res_eframe = frame_next;
                end else begin
                    n_phase = fefp_pkg::PH_TRIG;
                end
            end
            fefp_pkg::PH_TRIG: begin
                if (r_frame_index == 4'd0) begin
                    n_evt_trigger = i_data_byte;
                    n_phase       = fefp_pkg::PH_MODE;
                end else if (r_evt_trigger != i_data_byte) begin
                    res_valid  = 1'b1;
                    res_ecode  = fefp_pkg::ERR_TRIGGER;
                    res_eframe = frame_next;
                end else begin
                    n_phase = fefp_pkg::PH_MODE;
                end
            end
            fefp_pkg::PH_MODE: begin
                n_cur_board = i_data_byte[3:0];
                if (r_frame_index == 4'd0) begin
                    n_evt_mode = byte_mode;
                    n_phase    = fefp_pkg::PH_LENHI;
                end else if (r_evt_mode != byte_mode) begin
                    res_valid  = 1'b1;
                    res_ecode  = fefp_pkg::ERR_MODE;
                    res_eframe = i_data_byte[3:0];
                end else begin
                    n_phase = fefp_pkg::PH_LENHI;
                end
            end
            fefp_pkg::PH_LENHI: begin
                n_len_high = i_data_byte;
                n_phase    = fefp_pkg::PH_LENLO;
            end
            fefp_pkg::PH_LENLO: begin
                // count is nonzero once the body holds one whole signal
                if (frame_len < fefp_pkg::HEADER_LEN) begin
                    n_sig_left = 15'd0;
                end else if (uncomp) begin
                    n_sig_left = body_len[15:1];
                end else begin
                    n_sig_left = div3_prod[31:17];
                end
                n_sig_index    = 15'd0;
                n_byte_in_sig  = 2'd0;
                n_trailer_left = fefp_pkg::TRAILER_BYTES;
                if ((uncomp && frame_len >= 16'd8) || (!uncomp && frame_len >= 16'd9)) begin
                    n_phase = fefp_pkg::PH_SIGNAL;
                end else begin
                    n_phase = fefp_pkg::PH_TRAILER;
                end
            end
            fefp_pkg::PH_SIGNAL: begin
                priority if (r_byte_in_sig == 2'd0 && !uncomp) begin
                    n_held_chan   = i_data_byte;
                    n_byte_in_sig = 2'd1;
                end else if ((r_byte_in_sig == 2'd0 && uncomp) ||
                             (r_byte_in_sig == 2'd1 && !uncomp)) begin
                    n_held_high   = i_data_byte;
                    n_byte_in_sig = r_byte_in_sig + 2'd1;
                end else begin
                    res_valid     = 1'b1;
                    res_kind      = fefp_pkg::KIND_SIGNAL;
                    res_board     = r_cur_board;
                    res_channel   = uncomp ? r_sig_index : {7'd0, r_held_chan};
                    res_value     = {r_held_high, i_data_byte};
                    res_trigger   = r_evt_trigger;
                    res_mode      = r_evt_mode;
                    n_byte_in_sig = 2'd0;
                    n_sig_index   = r_sig_index + 15'd1;
                    n_sig_left    = r_sig_left - 15'd1;
                    if (r_sig_left == 15'd1) begin
                        n_phase = fefp_pkg::PH_TRAILER;
                    end
                end
            end
            fefp_pkg::PH_TRAILER: begin
                n_trailer_left = r_trailer_left - 3'd1;
                if (r_trailer_left == 3'd1) begin
                    n_phase = fefp_pkg::PH_SYNC1;
                    if (frame_next == r_frame_count) begin
                        n_frame_index = 4'd0;
                        res_valid     = 1'b1;
                        res_kind      = fefp_pkg::KIND_DONE;
                        res_board     = r_cur_board;
                        res_trigger   = r_evt_trigger;
                        res_mode      = r_evt_mode;
                    end else begin
                        n_frame_index = frame_next;
                    end
                end
            end
            default: ;
        endcase

        // every error restarts at the first sync byte of frame 0
        if (res_valid && res_ecode != fefp_pkg::ERR_NONE) begin
            res_kind      = fefp_pkg::KIND_ERROR;
            n_phase       = fefp_pkg::PH_SYNC1;
            n_frame_index = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= fefp_pkg::PH_SYNC1;
            r_frame_index  <= 4'd0;
            r_cur_board    <= 4'd0;
            r_evt_trigger  <= 8'd0;
            r_evt_mode     <= 5'd0;
            r_len_high     <= 8'd0;
            r_sig_left     <= 15'd0;
            r_sig_index    <= 15'd0;
            r_byte_in_sig  <= 2'd0;
            r_held_chan    <= 8'd0;
            r_held_high    <= 8'd0;
            r_trailer_left <= 3'd0;
        end else if (in_acc) begin
            r_phase        <= n_phase;
            r_frame_index  <= n_frame_index;
            r_cur_board    <= n_cur_board;
            r_evt_trigger  <= n_evt_trigger;
            r_evt_mode     <= n_evt_mode;
            r_len_high     <= n_len_high;
            r_sig_left     <= n_sig_left;
            r_sig_index    <= n_sig_index;
            r_byte_in_sig  <= n_byte_in_sig;
            r_held_chan    <= n_held_chan;
            r_held_high    <= n_held_high;
            r_trailer_left <= n_trailer_left;
        end
    end

    // output register: loads a new result, or empties once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_kind        <= res_kind;
            r_board_id    <= res_board;
            r_channel     <= res_channel;
            r_value       <= res_value;
            r_trigger     <= res_trigger;
            r_run_mode    <= res_mode;
            r_error_code  <= res_ecode;
            r_error_frame <= res_eframe;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_board_id    = r_board_id;
    assign o_channel     = r_channel;
    assign o_value       = r_value;
    assign o_trigger     = r_trigger;
    assign o_run_mode    = $signed(r_run_mode);
    assign o_error_code  = r_error_code;
    assign o_error_frame = r_error_frame;

endmodule

// ===== hdl/fefp_checker.sv =====
// ----------------------------------------------------------------------------
// fefp_checker: port-level checks of the front-end event frame parser
// Output hold, result field consistency and input readiness.
// ----------------------------------------------------------------------------
module fefp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         o_kind,
    input  logic [3:0]         o_board_id,
    input  logic [14:0]        o_channel,
    input  logic [15:0]        o_value,
    input  logic [7:0]         o_trigger,
    input  logic signed [4:0]  o_run_mode,
    input  logic [2:0]         o_error_code,
    input  logic [3:0]         o_error_frame
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_value) && $stable(o_channel)))
        else $error("result changed while stalled");

    // an empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // signals and event-done results carry no error information
    a_no_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != fefp_pkg::KIND_ERROR) |->
            (o_error_code == fefp_pkg::ERR_NONE && o_error_frame == 4'd0))
        else $error("error fields set on non-error result");

    // error results carry a real code and no event data
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == fefp_pkg::KIND_ERROR) |->
            (o_error_code != fefp_pkg::ERR_NONE && o_board_id == 4'd0 &&
             o_value == 16'd0 && o_trigger == 8'd0 && o_run_mode == 5'sd0))
        else $error("malformed error result");

    // kind code three is never produced
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind != 2'd3))
        else $error("undefined result kind");

endmodule

bind frontend_event_frame_parser fefp_checker u_fefp_checker (.*);
